// ===== rtl/oep_pkg.sv =====
// Types, codes and helpers shared by the orphan entry pool.
// Depends on nothing; used by oep_cell and orphan_entry_pool_unit.
package oep_pkg;

	localparam logic [3:0] OP_ADD    = 4'd0;
	localparam logic [3:0] OP_EXISTS = 4'd1;
	localparam logic [3:0] OP_TAKE   = 4'd2;
	localparam logic [3:0] OP_ERASE  = 4'd3;
	localparam logic [3:0] OP_PEER   = 4'd4;
	localparam logic [3:0] OP_EXPIRE = 4'd5;
	localparam logic [3:0] OP_LIMIT  = 4'd6;
	localparam logic [3:0] OP_STATS  = 4'd7;
	localparam logic [3:0] OP_LIST   = 4'd8;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ZERO_KEY = 3'd1;
	localparam logic [2:0] ST_ZERO_PAR = 3'd2;
	localparam logic [2:0] ST_OVERSIZE = 3'd3;
	localparam logic [2:0] ST_NO_TX    = 3'd4;
	localparam logic [2:0] ST_DUP      = 3'd5;

	localparam logic [1:0] CFG_MAX_ENTRIES = 2'd0;
	localparam logic [1:0] CFG_MAX_SIZE    = 2'd1;
	localparam logic [1:0] CFG_EXPIRY      = 2'd2;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [63:0] item_key;
		logic [63:0] parent_key;
		logic [15:0] peer_id;
		logic [31:0] now_time;
		logic [31:0] item_size;
		logic        has_transactions;
	} oep_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [63:0] out_key;
		logic [15:0] out_peer;
		logic [31:0] out_time;
		logic [6:0]  pool_count;
		logic [6:0]  aux_count;
		logic        last;
	} oep_out_t;

	// per-entry data besides valid, key and parent
	typedef struct packed {
		logic        mark;
		logic [15:0] peer;
		logic [31:0] tm;
		logic [31:0] ord;
	} oep_meta_t;

	// a is older than b: smaller time, ties to smaller insertion number
	function automatic logic older(logic [31:0] ta, logic [31:0] oa,
			logic [31:0] tb, logic [31:0] ob);
		return (ta < tb) || ((ta == tb) && (oa < ob));
	endfunction

endpackage

// ===== rtl/oep_cell.sv =====
// One storage cell of the entry ring: valid, key, parent and metadata.
// Depends on oep_pkg for the metadata type.
module oep_cell #(
	parameter int KEY_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_d,
	input  logic [KEY_BITS-1:0]   key_d,
	input  logic [KEY_BITS-1:0]   par_d,
	input  oep_pkg::oep_meta_t    meta_d,
	output logic                  v,
	output logic [KEY_BITS-1:0]   key,
	output logic [KEY_BITS-1:0]   par,
	output oep_pkg::oep_meta_t    meta
);

	logic                v_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] par_q;
	oep_pkg::oep_meta_t  meta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			key_q  <= key_d;
			par_q  <= par_d;
			meta_q <= meta_d;
		end
	end

	assign v    = v_q;
	assign key  = key_q;
	assign par  = par_q;
	assign meta = meta_q;

endmodule

// ===== rtl/orphan_entry_pool_unit.sv =====
// Orphan entry pool: ring of oep_cell entries rotated past one head stage.
// Depends on oep_pkg and oep_cell.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------
//  in      | in_valid/in_stall  | in_data  (oep_in_t)
//  out     | out_valid/out_stall| out_data (oep_out_t)
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each scan is one full turn of the ring, one entry at the head per cycle.
// add searches the ring, then writes it; take children counts the children, then finds each in turn;
// list counts the parents, then emits each; limit evicts the oldest entry until the pool fits.
// Reset empties the pool at once. A result transfer stalled on out only holds
// the sequencer when the next result is due; one finished result may wait.
module orphan_entry_pool_unit #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  oep_pkg::oep_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output oep_pkg::oep_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_ADD1, S_ADD2, S_SCAN, S_TCNT, S_TSRCH, S_LIMIT, S_PCNT, S_PLIST, S_EMIT
	} state_t;

	state_t state_q, ret_q;

	// ring
	logic                c_v    [CAPACITY];
	logic [KEY_BITS-1:0] c_key  [CAPACITY];
	logic [KEY_BITS-1:0] c_par  [CAPACITY];
	oep_pkg::oep_meta_t  c_meta [CAPACITY];

	logic                t_v;
	logic [KEY_BITS-1:0] t_key, t_par;
	oep_pkg::oep_meta_t  t_meta;
	logic                shift;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_ring
		if (i == CAPACITY - 1) begin : g_tail
			oep_cell #(.KEY_BITS(KEY_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(shift),
				.v_d(t_v), .key_d(t_key), .par_d(t_par), .meta_d(t_meta),
				.v(c_v[i]), .key(c_key[i]), .par(c_par[i]), .meta(c_meta[i])
			);
		end else begin : g_mid
			oep_cell #(.KEY_BITS(KEY_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(shift),
				.v_d(c_v[i+1]), .key_d(c_key[i+1]), .par_d(c_par[i+1]),
				.meta_d(c_meta[i+1]),
				.v(c_v[i]), .key(c_key[i]), .par(c_par[i]), .meta(c_meta[i])
			);
		end
	end

	// configuration
	logic [5:0]  max_entries_q;
	logic [31:0] max_size_q, expiry_q;

	// operation context
	logic [3:0]          op_q;
	logic [KEY_BITS-1:0] key_q, par_q;
	logic [15:0]         peer_q;
	logic [31:0]         now_q, ctr_q, nord_q;
	logic [CW-1:0]       count_q, n_q, k_q, pc_q;
	logic [IW-1:0]       cnt_q;

	// scan accumulators
	logic                found_q, fr_v_q, pend_v_q, pp_v_q, take_q;
	logic [IW-1:0]       fr_idx_q, pend_idx_q;
	logic                wr_v_q, dr_v_q;
	logic [IW-1:0]       wr_idx_q, dr_idx_q;
	logic [KEY_BITS-1:0] pp_q;
	logic                best_v_q;
	logic [IW-1:0]       best_idx_q;
	logic [31:0]         best_t_q, best_o_q;
	logic [15:0]         best_peer_q;
	logic [KEY_BITS-1:0] best_key_q, best_par_q;

	oep_pkg::oep_out_t res_q, out_q;
	logic              out_valid_q;
	oep_pkg::oep_out_t res_init, emit_d;

	// head stage
	logic                hv;
	logic [KEY_BITS-1:0] hk, hp;
	oep_pkg::oep_meta_t  hm;
	logic key_hit, par_hit, pend_here, exp_hit, wr, clr, m_new, cand, inc, pass_end;
	logic                nb_v;
	logic [IW-1:0]       nb_idx;
	logic [31:0]         nb_t, nb_o;
	logic [15:0]         nb_peer;
	logic [KEY_BITS-1:0] nb_key, nb_par;
	logic [CW-1:0]       count_d, n_d;
	logic                found_d, fr_v_d;
	logic [IW-1:0]       fr_idx_d;
	logic                full, over, new_older;

	assign hv = c_v[0];
	assign hk = c_key[0];
	assign hp = c_par[0];
	assign hm = c_meta[0];

	always_comb begin
		shift = (state_q != S_IDLE) && (state_q != S_EMIT);
		pass_end = shift && (cnt_q == LAST_IDX);
		key_hit = hv && (hk == key_q);
		par_hit = hv && (hp == key_q);
		pend_here = pend_v_q && (cnt_q == pend_idx_q);
		exp_hit = ({1'b0, hm.tm} + {1'b0, expiry_q}) < {1'b0, now_q};
		wr = 1'b0;
		clr = 1'b0;
		cand = 1'b0;
		inc = 1'b0;
		m_new = hm.mark;
		case (state_q)
			S_ADD1: cand = hv && (!best_v_q ||
				oep_pkg::older(hm.tm, hm.ord, best_t_q, best_o_q));
			S_ADD2: begin
				wr = wr_v_q && (cnt_q == wr_idx_q);
				clr = dr_v_q && (cnt_q == dr_idx_q);
			end
			S_SCAN: begin
				unique case (op_q)
					oep_pkg::OP_ERASE:  clr = key_hit;
					oep_pkg::OP_PEER:   clr = hv && (hm.peer == peer_q);
					oep_pkg::OP_EXPIRE: clr = hv && exp_hit;
					default: clr = 1'b0;
				endcase
				inc = clr && ((op_q == oep_pkg::OP_PEER) || (op_q == oep_pkg::OP_EXPIRE));
			end
			S_TCNT: inc = par_hit;
			S_TSRCH: begin
				clr = pend_here;
				cand = par_hit && !pend_here && (!best_v_q || (hm.ord < best_o_q));
			end
			S_LIMIT: begin
				clr = pend_here;
				cand = hv && !pend_here && (!best_v_q ||
					oep_pkg::older(hm.tm, hm.ord, best_t_q, best_o_q));
			end
			S_PCNT, S_PLIST: begin
				if (!pp_v_q) begin
					m_new = 1'b0;
				end else if (hv && (hp == pp_q)) begin
					m_new = 1'b1;
				end
				cand = hv && !m_new && !best_v_q;
			end
			default: cand = 1'b0;
		endcase

		t_v = wr ? 1'b1 : (clr ? 1'b0 : hv);
		t_key = wr ? key_q : hk;
		t_par = wr ? par_q : hp;
		if (wr) begin
			t_meta = '{mark: 1'b0, peer: peer_q, tm: now_q, ord: nord_q};
		end else begin
			t_meta = '{mark: m_new, peer: hm.peer, tm: hm.tm, ord: hm.ord};
		end
		count_d = count_q + CW'(wr && !hv) - CW'(clr && hv);
		found_d = found_q | (key_hit && ((state_q == S_ADD1) || (state_q == S_SCAN)));
		fr_v_d = fr_v_q;
		fr_idx_d = fr_idx_q;
		if (state_q == S_ADD1 && !fr_v_q && !hv) begin
			fr_v_d = 1'b1;
			fr_idx_d = cnt_q;
		end

		nb_v = best_v_q | cand;
		nb_idx = cand ? cnt_q : best_idx_q;
		nb_t = cand ? hm.tm : best_t_q;
		nb_o = cand ? hm.ord : best_o_q;
		nb_peer = cand ? hm.peer : best_peer_q;
		nb_key = cand ? hk : best_key_q;
		nb_par = cand ? hp : best_par_q;

		// a new parent found, or one more eviction still needed
		if (pass_end && nb_v && ((state_q == S_PCNT) ||
				((state_q == S_LIMIT) && (7'(count_d) > 7'(max_entries_q))))) begin
			inc = 1'b1;
		end
		n_d = n_q + CW'(inc);

		full = count_q >= CW'(CAPACITY);
		over = (7'(count_q) + 7'd1) > 7'(max_entries_q);
		new_older = !nb_v || oep_pkg::older(now_q, ctr_q, nb_t, nb_o);

		res_init = '0;
		res_init.last = 1'b1;
		if (in_data.opcode == oep_pkg::OP_ADD) begin
			if (in_data.item_key[KEY_BITS-1:0] == '0) begin
				res_init.status = oep_pkg::ST_ZERO_KEY;
			end else if (in_data.parent_key[KEY_BITS-1:0] == '0) begin
				res_init.status = oep_pkg::ST_ZERO_PAR;
			end else if (in_data.item_size > max_size_q) begin
				res_init.status = oep_pkg::ST_OVERSIZE;
			end else if (!in_data.has_transactions) begin
				res_init.status = oep_pkg::ST_NO_TX;
			end
		end

		emit_d = res_q;
		emit_d.pool_count = take_q ? 7'(pc_q) : 7'(count_q);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			max_entries_q <= 6'd63;
			max_size_q <= 32'd4000000;
			expiry_q <= 32'd3600;
			ctr_q <= '0;
			count_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			best_v_q <= 1'b0;
			pend_v_q <= 1'b0;
			pp_v_q <= 1'b0;
			take_q <= 1'b0;
			found_q <= 1'b0;
			fr_v_q <= 1'b0;
			wr_v_q <= 1'b0;
			dr_v_q <= 1'b0;
			n_q <= '0;
			k_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					oep_pkg::CFG_MAX_ENTRIES: max_entries_q <= cfg_data[5:0];
					oep_pkg::CFG_MAX_SIZE:    max_size_q <= cfg_data;
					oep_pkg::CFG_EXPIRY:      expiry_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end

			if (shift) begin
				cnt_q <= pass_end ? '0 : cnt_q + IW'(1);
				count_q <= count_d;
				n_q <= n_d;
				found_q <= found_d;
				fr_v_q <= fr_v_d;
				fr_idx_q <= fr_idx_d;
				// every scan starts with no candidate
				best_v_q <= nb_v && !pass_end;
				best_idx_q <= nb_idx;
				best_t_q <= nb_t;
				best_o_q <= nb_o;
				best_peer_q <= nb_peer;
				best_key_q <= nb_key;
				best_par_q <= nb_par;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= in_data.opcode;
						key_q <= in_data.item_key[KEY_BITS-1:0];
						par_q <= in_data.parent_key[KEY_BITS-1:0];
						peer_q <= in_data.peer_id;
						now_q <= in_data.now_time;
						cnt_q <= '0;
						best_v_q <= 1'b0;
						found_q <= 1'b0;
						fr_v_q <= 1'b0;
						pend_v_q <= 1'b0;
						pp_v_q <= 1'b0;
						take_q <= 1'b0;
						wr_v_q <= 1'b0;
						dr_v_q <= 1'b0;
						n_q <= '0;
						k_q <= '0;
						res_q <= res_init;
						ret_q <= S_IDLE;
						unique case (in_data.opcode) inside
							oep_pkg::OP_ADD: begin
								if (res_init.status != oep_pkg::ST_OK) begin
									state_q <= S_EMIT;
								end else begin
									state_q <= S_ADD1;
								end
							end
							oep_pkg::OP_EXISTS, oep_pkg::OP_ERASE, oep_pkg::OP_PEER,
							oep_pkg::OP_EXPIRE: state_q <= S_SCAN;
							oep_pkg::OP_TAKE:  state_q <= S_TCNT;
							oep_pkg::OP_LIMIT: state_q <= S_LIMIT;
							oep_pkg::OP_STATS, oep_pkg::OP_LIST: state_q <= S_PCNT;
							default: state_q <= S_EMIT;
						endcase
					end
				end

				S_ADD1: begin
					if (pass_end) begin
						if (found_d) begin
							res_q.status <= oep_pkg::ST_DUP;
							state_q <= S_EMIT;
						end else begin
							nord_q <= ctr_q;
							ctr_q <= ctr_q + 32'd1;
							if (full) begin
								res_q.aux_count <= 7'd1;
								if (!nb_v || (now_q < nb_t)) begin
									state_q <= S_EMIT;
								end else begin
									wr_v_q <= 1'b1;
									wr_idx_q <= nb_idx;
									res_q.found <= 1'b1;
									state_q <= S_ADD2;
								end
							end else if (over && new_older) begin
								// new entry is the oldest: it is evicted straight away
								res_q.aux_count <= 7'd1;
								state_q <= S_EMIT;
							end else begin
								wr_v_q <= 1'b1;
								wr_idx_q <= fr_idx_d;
								dr_v_q <= over;
								dr_idx_q <= nb_idx;
								res_q.found <= 1'b1;
								res_q.aux_count <= 7'(over);
								state_q <= S_ADD2;
							end
						end
					end
				end

				S_ADD2: begin
					if (pass_end) begin
						state_q <= S_EMIT;
					end
				end

				S_SCAN: begin
					if (pass_end) begin
						if (op_q == oep_pkg::OP_EXISTS) begin
							res_q.found <= found_d;
						end else if (op_q == oep_pkg::OP_ERASE) begin
							res_q.found <= found_d;
							res_q.aux_count <= 7'(found_d);
						end else begin
							res_q.aux_count <= 7'(n_d);
						end
						state_q <= S_EMIT;
					end
				end

				S_TCNT: begin
					if (pass_end) begin
						if (n_d == '0) begin
							state_q <= S_EMIT;
						end else begin
							pc_q <= count_q - n_d;
							take_q <= 1'b1;
							state_q <= S_TSRCH;
						end
					end
				end

				S_TSRCH: begin
					if (pass_end) begin
						pend_v_q <= nb_v;
						pend_idx_q <= nb_idx;
						if (nb_v) begin
							res_q.found <= 1'b1;
							res_q.out_key <= 64'(nb_key);
							res_q.out_peer <= nb_peer;
							res_q.out_time <= nb_t;
							res_q.aux_count <= 7'(n_q);
							res_q.last <= (k_q + CW'(1)) == n_q;
							k_q <= k_q + CW'(1);
							ret_q <= S_TSRCH;
							state_q <= S_EMIT;
						end else begin
							take_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end

				S_LIMIT: begin
					if (pass_end) begin
						if ((7'(count_d) > 7'(max_entries_q)) && nb_v) begin
							pend_v_q <= 1'b1;
							pend_idx_q <= nb_idx;
						end else begin
							pend_v_q <= 1'b0;
							res_q.aux_count <= 7'(n_q);
							state_q <= S_EMIT;
						end
					end
				end

				S_PCNT: begin
					if (pass_end) begin
						if (nb_v) begin
							pp_q <= nb_par;
							pp_v_q <= 1'b1;
						end else if (op_q == oep_pkg::OP_STATS || n_q == '0) begin
							res_q.aux_count <= 7'(n_q);
							state_q <= S_EMIT;
						end else begin
							pp_v_q <= 1'b0;
							state_q <= S_PLIST;
						end
					end
				end

				S_PLIST: begin
					if (pass_end) begin
						if (nb_v) begin
							pp_q <= nb_par;
							pp_v_q <= 1'b1;
							res_q.found <= 1'b1;
							res_q.out_key <= 64'(nb_par);
							res_q.aux_count <= 7'(n_q);
							res_q.last <= (k_q + CW'(1)) == n_q;
							k_q <= k_q + CW'(1);
							ret_q <= S_PLIST;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end

				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_q <= emit_d;
						out_valid_q <= 1'b1;
						state_q <= ret_q;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== bench/orphan_entry_pool_unit_tb.sv =====
// Self-checking bench for orphan_entry_pool_unit: a directed table, then random phases
// under several register settings, each result checked against a pool model or its row.
// Depends on oep_pkg and the RTL of orphan_entry_pool_unit.
`timescale 1ns / 1ps

module orphan_entry_pool_unit_tb;

	localparam int SLOTS = 64;
	localparam int CYCLE_LIMIT = 20000000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	oep_pkg::oep_in_t  in_data;
	logic              out_valid;
	logic              out_stall;
	oep_pkg::oep_out_t out_data;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [31:0]       cfg_data;

	orphan_entry_pool_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// pool model state
	bit          m_vld[SLOTS];
	logic [63:0] m_key[SLOTS];
	logic [63:0] m_par[SLOTS];
	logic [15:0] m_peer[SLOTS];
	logic [31:0] m_tm[SLOTS];
	logic [31:0] m_ord[SLOTS];
	logic [31:0] m_ictr;
	int          m_cnt;
	logic [5:0]  lim_entries;
	logic [31:0] lim_size;
	logic [31:0] expiry_s;

	oep_pkg::oep_out_t pending_results[$];
	int       errors;
	int       cycles;
	bit       quiet;
	int       stall_cnt;
	logic [31:0] base_time;

	typedef struct {
		oep_pkg::oep_in_t  d;
		bit                typed;
		oep_pkg::oep_out_t res;
	} stim_row_t;

	stim_row_t table_rows[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic bit is_older(int a, int b);
		if (m_tm[a] != m_tm[b]) return m_tm[a] < m_tm[b];
		return m_ord[a] < m_ord[b];
	endfunction

	function automatic int slot_of_key(logic [63:0] k);
		for (int i = 0; i < SLOTS; i++)
			if (m_vld[i] && m_key[i] == k) return i;
		return -1;
	endfunction

	function automatic int oldest_slot();
		int best;
		best = -1;
		for (int i = 0; i < SLOTS; i++)
			if (m_vld[i] && (best < 0 || is_older(i, best))) best = i;
		return best;
	endfunction

	function automatic bit first_of_parent(int i);
		if (!m_vld[i]) return 0;
		for (int j = 0; j < i; j++)
			if (m_vld[j] && m_par[j] == m_par[i]) return 0;
		return 1;
	endfunction

	function automatic int parent_total();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++) if (first_of_parent(i)) n++;
		return n;
	endfunction

	function automatic void drop(int i);
		if (m_vld[i]) begin
			m_vld[i] = 0;
			m_cnt--;
		end
	endfunction

	function automatic void fill(int i, oep_pkg::oep_in_t d);
		m_vld[i] = 1;
		m_key[i] = d.item_key;
		m_par[i] = d.parent_key;
		m_peer[i] = d.peer_id;
		m_tm[i] = d.now_time;
		m_ord[i] = m_ictr;
		m_ictr++;
	endfunction

	function automatic void push_result(logic [2:0] st, logic fnd, logic [63:0] k,
			logic [15:0] pr, logic [31:0] tm, int aux, logic lst);
		oep_pkg::oep_out_t r;
		r.status = st;
		r.found = fnd;
		r.out_key = k;
		r.out_peer = pr;
		r.out_time = tm;
		r.pool_count = 7'(m_cnt);
		r.aux_count = 7'(aux);
		r.last = lst;
		pending_results.insert(pending_results.size(), r);
	endfunction

	// updates the pool model for one accepted item and queues its results
	function automatic void predict_pool(oep_pkg::oep_in_t d);
		logic [2:0] st;
		int removed, o, i, n, best, total, k;
		int picked[SLOTS];
		bit taken[SLOTS];
		removed = 0;
		case (d.opcode)
			oep_pkg::OP_ADD: begin
				st = oep_pkg::ST_OK;
				if (d.item_key == 0) st = oep_pkg::ST_ZERO_KEY;
				else if (d.parent_key == 0) st = oep_pkg::ST_ZERO_PAR;
				else if (d.item_size > lim_size) st = oep_pkg::ST_OVERSIZE;
				else if (!d.has_transactions) st = oep_pkg::ST_NO_TX;
				else if (slot_of_key(d.item_key) >= 0) st = oep_pkg::ST_DUP;
				if (st != oep_pkg::ST_OK) begin
					push_result(st, 0, 0, 0, 0, 0, 1);
					return;
				end
				if (m_cnt >= SLOTS) begin
					o = oldest_slot();
					removed = 1;
					if (o < 0 || d.now_time < m_tm[o]) m_ictr++;
					else fill(o, d);
				end else begin
					for (i = 0; i < SLOTS && m_vld[i]; i++) ;
					if (i < SLOTS) begin
						fill(i, d);
						m_cnt++;
					end
					if (m_cnt > lim_entries) begin
						o = oldest_slot();
						if (o >= 0) begin
							drop(o);
							removed = 1;
						end
					end
				end
				push_result(oep_pkg::ST_OK, slot_of_key(d.item_key) >= 0, 0, 0, 0, removed, 1);
			end
			oep_pkg::OP_EXISTS:
				push_result(oep_pkg::ST_OK, slot_of_key(d.item_key) >= 0, 0, 0, 0, 0, 1);
			oep_pkg::OP_TAKE: begin
				n = 0;
				for (i = 0; i < SLOTS; i++) taken[i] = 0;
				forever begin
					best = -1;
					for (i = 0; i < SLOTS; i++)
						if (m_vld[i] && !taken[i] && m_par[i] == d.item_key &&
								(best < 0 || m_ord[i] < m_ord[best]))
							best = i;
					if (best < 0) break;
					taken[best] = 1;
					picked[n] = best;
					n++;
				end
				for (k = 0; k < n; k++) drop(picked[k]);
				if (n == 0) push_result(oep_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
				for (k = 0; k < n; k++)
					push_result(oep_pkg::ST_OK, 1, m_key[picked[k]], m_peer[picked[k]],
						m_tm[picked[k]], n, k == n - 1);
			end
			oep_pkg::OP_ERASE: begin
				o = slot_of_key(d.item_key);
				if (o >= 0) drop(o);
				push_result(oep_pkg::ST_OK, o >= 0, 0, 0, 0, (o >= 0) ? 1 : 0, 1);
			end
			oep_pkg::OP_PEER, oep_pkg::OP_EXPIRE: begin
				for (i = 0; i < SLOTS; i++) begin
					if (!m_vld[i]) continue;
					if (d.opcode == oep_pkg::OP_PEER ? (m_peer[i] == d.peer_id) :
							({1'b0, m_tm[i]} + {1'b0, expiry_s} < {1'b0, d.now_time})) begin
						drop(i);
						removed++;
					end
				end
				push_result(oep_pkg::ST_OK, 0, 0, 0, 0, removed, 1);
			end
			oep_pkg::OP_LIMIT: begin
				while (m_cnt > lim_entries) begin
					o = oldest_slot();
					if (o < 0) break;
					drop(o);
					removed++;
				end
				push_result(oep_pkg::ST_OK, 0, 0, 0, 0, removed, 1);
			end
			oep_pkg::OP_STATS: push_result(oep_pkg::ST_OK, 0, 0, 0, 0, parent_total(), 1);
			oep_pkg::OP_LIST: begin
				total = parent_total();
				if (total == 0) push_result(oep_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
				k = 0;
				for (i = 0; i < SLOTS; i++)
					if (first_of_parent(i)) begin
						k++;
						push_result(oep_pkg::ST_OK, 1, m_par[i], 0, 0, total, k == total);
					end
			end
			default: push_result(oep_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
		endcase
	endfunction

	task automatic send_item(oep_pkg::oep_in_t d, bit typed, oep_pkg::oep_out_t res);
		int n;
		in_data <= d;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_pool(d);
		if (typed) begin
			// hand-written expectation, pool count taken from the model
			res.pool_count = pending_results[$].pool_count;
			pending_results[pending_results.size() - 1] = res;
		end
		n = quiet ? 0 : gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			oep_pkg::CFG_MAX_ENTRIES: lim_entries = val[5:0];
			oep_pkg::CFG_MAX_SIZE:    lim_size = val;
			oep_pkg::CFG_EXPIRY:      expiry_s = val;
			default: ;
		endcase
	endtask

	function automatic oep_pkg::oep_in_t mk(logic [3:0] op, logic [63:0] k, logic [63:0] p,
			logic [15:0] pr, logic [31:0] t, logic [31:0] sz, logic tx);
		oep_pkg::oep_in_t d;
		d.opcode = op;
		d.item_key = k;
		d.parent_key = p;
		d.peer_id = pr;
		d.now_time = t;
		d.item_size = sz;
		d.has_transactions = tx;
		return d;
	endfunction

	function automatic void add_row(oep_pkg::oep_in_t d, bit typed, logic [2:0] st,
			logic fnd);
		stim_row_t r;
		r.d = d;
		r.typed = typed;
		r.res = '0;
		r.res.status = st;
		r.res.found = fnd;
		r.res.last = 1'b1;
		table_rows.insert(table_rows.size(), r);
	endfunction

	function automatic logic [63:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return 64'd0;
		if (r < 10) return {$urandom, $urandom};
		return 64'($urandom_range(1, 40));
	endfunction

	function automatic logic [63:0] pick_parent();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return 64'd0;
		if (r < 8) return {$urandom, $urandom};
		return 64'($urandom_range(1, 8));
	endfunction

	function automatic oep_pkg::oep_in_t random_item();
		oep_pkg::oep_in_t d;
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) d.opcode = oep_pkg::OP_ADD;
		else if (r < 50) d.opcode = oep_pkg::OP_EXISTS;
		else if (r < 60) d.opcode = oep_pkg::OP_TAKE;
		else if (r < 68) d.opcode = oep_pkg::OP_ERASE;
		else if (r < 73) d.opcode = oep_pkg::OP_PEER;
		else if (r < 79) d.opcode = oep_pkg::OP_EXPIRE;
		else if (r < 85) d.opcode = oep_pkg::OP_LIMIT;
		else if (r < 91) d.opcode = oep_pkg::OP_STATS;
		else if (r < 97) d.opcode = oep_pkg::OP_LIST;
		else d.opcode = 4'($urandom_range(9, 15));
		d.item_key = (d.opcode == oep_pkg::OP_TAKE) ? pick_parent() : pick_key();
		d.parent_key = pick_parent();
		d.peer_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
		base_time += $urandom_range(0, 400);
		d.now_time = ($urandom_range(0, 19) == 0) ? $urandom : base_time;
		d.item_size = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2000);
		d.has_transactions = ($urandom_range(0, 9) != 0);
		return d;
	endfunction

	// response check
	task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		oep_pkg::oep_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result transfer %h", $time, out_data);
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("status", e.status, out_data.status);
				check_field("found", e.found, out_data.found);
				check_field("out_key", e.out_key, out_data.out_key);
				check_field("out_peer", e.out_peer, out_data.out_peer);
				check_field("out_time", e.out_time, out_data.out_time);
				check_field("pool_count", e.pool_count, out_data.pool_count);
				check_field("aux_count", e.aux_count, out_data.aux_count);
				check_field("last", e.last, out_data.last);
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (stall_cnt > 0) begin
			out_stall <= 1'b1;
			stall_cnt--;
		end else begin
			out_stall <= 1'b0;
			if (!quiet && $urandom_range(0, 3) == 0) stall_cnt = gap_len();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: timeout, %0d results outstanding", $time, pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [63:0] ones;
		ones = '1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = oep_pkg::CFG_MAX_ENTRIES;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		quiet = 0;
		stall_cnt = 0;
		base_time = 32'd5000;
		for (int i = 0; i < SLOTS; i++) m_vld[i] = 0;
		m_ictr = 0;
		m_cnt = 0;
		lim_entries = 6'd63;
		lim_size = 32'd4000000;
		expiry_s = 32'd3600;

		// empty pool, error codes, then a little of every operation
		add_row(mk(oep_pkg::OP_STATS, 0, 0, 0, 0, 0, 0), 1, oep_pkg::ST_OK, 0);
		add_row(mk(oep_pkg::OP_LIST, 0, 0, 0, 0, 0, 0), 1, oep_pkg::ST_OK, 0);
		add_row(mk(oep_pkg::OP_TAKE, 5, 0, 0, 0, 0, 0), 1, oep_pkg::ST_OK, 0);
		add_row(mk(oep_pkg::OP_EXISTS, ones, 0, 0, 0, 0, 0), 1, oep_pkg::ST_OK, 0);
		add_row(mk(4'd9, 1, 1, 1, 1, 1, 1), 1, oep_pkg::ST_OK, 0);
		add_row(mk(4'd15, ones, ones, 16'hFFFF, '1, '1, 1), 1, oep_pkg::ST_OK, 0);
		add_row(mk(oep_pkg::OP_ADD, 0, 7, 1, 100, 10, 1), 1, oep_pkg::ST_ZERO_KEY, 0);
		add_row(mk(oep_pkg::OP_ADD, 3, 0, 1, 100, 10, 1), 1, oep_pkg::ST_ZERO_PAR, 0);
		add_row(mk(oep_pkg::OP_ADD, 3, 7, 1, 100, 32'hFFFFFFFF, 1), 1,
			oep_pkg::ST_OVERSIZE, 0);
		add_row(mk(oep_pkg::OP_ADD, 3, 7, 1, 100, 10, 0), 1, oep_pkg::ST_NO_TX, 0);
		add_row(mk(oep_pkg::OP_ADD, ones, ones, 16'hFFFF, 32'hFFFFFFFF, 32'd4000000, 1),
			0, 0, 0);
		add_row(mk(oep_pkg::OP_ADD, ones, 7, 1, 100, 10, 1), 1, oep_pkg::ST_DUP, 0);
		add_row(mk(oep_pkg::OP_ADD, 3, 7, 16'h0001, 100, 0, 1), 0, 0, 0);
		add_row(mk(oep_pkg::OP_ADD, 4, 7, 16'h0002, 100, 0, 1), 0, 0, 0);
		add_row(mk(oep_pkg::OP_ADD, 5, 9, 16'h0002, 50, 0, 1), 0, 0, 0);
		add_row(mk(oep_pkg::OP_EXISTS, 4, 0, 0, 0, 0, 0), 0, 0, 0);
		add_row(mk(oep_pkg::OP_STATS, 0, 0, 0, 0, 0, 0), 0, 0, 0);
		add_row(mk(oep_pkg::OP_LIST, 0, 0, 0, 0, 0, 0), 0, 0, 0);
		add_row(mk(oep_pkg::OP_TAKE, 7, 0, 0, 0, 0, 0), 0, 0, 0);
		add_row(mk(oep_pkg::OP_ERASE, 5, 0, 0, 0, 0, 0), 0, 0, 0);
		add_row(mk(oep_pkg::OP_ERASE, 5, 0, 0, 0, 0, 0), 0, 0, 0);
		add_row(mk(oep_pkg::OP_ADD, 6, 8, 16'h0003, 10, 0, 1), 0, 0, 0);
		add_row(mk(oep_pkg::OP_PEER, 0, 0, 16'hFFFF, 0, 0, 0), 0, 0, 0);
		add_row(mk(oep_pkg::OP_EXPIRE, 0, 0, 0, 32'd3000, 0, 0), 0, 0, 0);
		add_row(mk(oep_pkg::OP_LIMIT, 0, 0, 0, 0, 0, 0), 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i]) send_item(table_rows[i].d, table_rows[i].typed, table_rows[i].res);

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					write_reg(oep_pkg::CFG_MAX_ENTRIES, 32'd1);
					write_reg(oep_pkg::CFG_MAX_SIZE, 32'd0);
					write_reg(oep_pkg::CFG_EXPIRY, 32'd0);
				end
				1: begin
					write_reg(oep_pkg::CFG_MAX_ENTRIES, 32'd63);
					write_reg(oep_pkg::CFG_MAX_SIZE, 32'hFFFFFFFF);
					write_reg(oep_pkg::CFG_EXPIRY, 32'hFFFFFFFF);
				end
				default: begin
					write_reg(oep_pkg::CFG_MAX_ENTRIES, $urandom_range(1, 63));
					write_reg(oep_pkg::CFG_MAX_SIZE, $urandom_range(200, 2500));
					write_reg(oep_pkg::CFG_EXPIRY, $urandom_range(0, 3000));
				end
			endcase
			quiet = (ph == 3);
			for (int n = 0; n < 23; n++) send_item(random_item(), 0, '0);
		end

		quiet = 0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/oep_pkg.sv
rtl/oep_cell.sv
rtl/orphan_entry_pool_unit.sv
bench/orphan_entry_pool_unit_tb.sv
